### hw/rtl/dxt_pkg.sv
// Shared types, constants and arithmetic helpers for the DXT block decoder.
// Depends on nothing; used by every file under hw/rtl.
`default_nettype none

package dxt_pkg;

   localparam int unsigned PixelsPerBlock = 16;
   localparam int unsigned CntWidth       = $clog2(PixelsPerBlock);
   localparam logic [CntWidth-1:0] LastPixel = CntWidth'(PixelsPerBlock - 1);

   localparam logic [13:0] Recip3 = 14'd10923;
   localparam logic [12:0] Recip5 = 13'd6554;
   localparam logic [12:0] Recip7 = 13'd4682;
   localparam int unsigned RecipShift = 15;

   localparam logic [7:0] AlphaOpaque = 8'hFF;
   localparam logic [7:0] AlphaClear  = 8'h00;

   typedef enum logic {
      FMT_DXT1 = 1'b0,
      FMT_DXT5 = 1'b1
   } format_type;

   typedef struct packed {
      logic [63:0] color_block;
      logic [63:0] alpha_block;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [1:0] pixel_x;
      logic [1:0] pixel_y;
      logic       last_pixel;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   typedef rgb_type [3:0]         color_pal_type;
   typedef logic [7:0][7:0]       alpha_pal_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic rgb_type split565(input logic [15:0] c);
      rgb_type o;
      o.r = widen5(c[15:11]);
      o.g = widen6(c[10:5]);
      o.b = widen5(c[4:0]);
      return o;
   endfunction

   // x <= 765
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [23:0] p;
      p = 24'(x) * 24'(Recip3);
      return p[RecipShift +: 8];
   endfunction

   // x <= 1275
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [23:0] p;
      p = 24'(x) * 24'(Recip5);
      return p[RecipShift +: 8];
   endfunction

   // x <= 1785
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [23:0] p;
      p = 24'(x) * 24'(Recip7);
      return p[RecipShift +: 8];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/dxt_color_pal.sv
// Four-entry colour palette from the two RGB565 endpoints of a block.
// Depends on dxt_pkg.
`default_nettype none

module dxt_color_pal
   import dxt_pkg::*;
(
   input  var format_type    mode,
   input  var logic [15:0]   endpoint0,
   input  var logic [15:0]   endpoint1,
   output var color_pal_type palette
);

   rgb_type e0;
   rgb_type e1;
   logic    four;

   assign e0   = split565(endpoint0);
   assign e1   = split565(endpoint1);
   assign four = (mode == FMT_DXT5) || (endpoint0 > endpoint1);

   function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
      return div3(10'({a, 1'b0}) + 10'(b));
   endfunction

   function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = 9'(a) + 9'(b);
      return s[8:1];
   endfunction

   always_comb begin
      palette[0] = e0;
      palette[1] = e1;
      if (four) begin
         palette[2].r = third(e0.r, e1.r);
         palette[2].g = third(e0.g, e1.g);
         palette[2].b = third(e0.b, e1.b);
         palette[3].r = third(e1.r, e0.r);
         palette[3].g = third(e1.g, e0.g);
         palette[3].b = third(e1.b, e0.b);
      end else begin
         palette[2].r = half(e0.r, e1.r);
         palette[2].g = half(e0.g, e1.g);
         palette[2].b = half(e0.b, e1.b);
         palette[3]   = '0;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/dxt_alpha_pal.sv
// Eight-entry interpolated alpha palette of a DXT5 block.
// Depends on dxt_pkg.
`default_nettype none

module dxt_alpha_pal
   import dxt_pkg::*;
(
   input  var logic [7:0]    a0,
   input  var logic [7:0]    a1,
   output var alpha_pal_type palette
);

   always_comb begin : mix
      logic [10:0] s;
      palette    = '0;
      palette[0] = a0;
      palette[1] = a1;
      if (a0 > a1) begin
         for (int j = 1; j < 7; j++) begin
            s = 11'(a0) * 11'(7 - j) + 11'(a1) * 11'(j);
            palette[j + 1] = div7(s);
         end
      end else begin
         for (int j = 1; j < 5; j++) begin
            s = 11'(a0) * 11'(5 - j) + 11'(a1) * 11'(j);
            palette[j + 1] = div5(s);
         end
         palette[6] = AlphaClear;
         palette[7] = AlphaOpaque;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/dxt_block_decoder.sv
// Top level of the S3TC DXT1/DXT5 block decoder: input register, palette
// register with pixel counter, output register. Depends on dxt_pkg,
// dxt_color_pal and dxt_alpha_pal.
//
// Channel  Dir  Handshake              Beat
// req      in   req_valid / req_stall  req_payload_type, one 4x4 block
// rsp      out  rsp_valid / rsp_stall  rsp_payload_type, one pixel, row-major
// csr      in   csr_wr_en              csr_wr_data = format_mode (0 DXT1, 1 DXT5)
//
// One pixel beat per cycle while rsp_stall is low; the pixel counter on the palette
// register counts a block's 16 pixels. A new block is taken while the previous
// one drains. The first pixel passes the input, palette and output registers
// before it shows on rsp. Reset clears all valids and sets format_mode to DXT1.
// rsp_stall holds the output beat; req_stall is high while a block waits.
`default_nettype none

module dxt_block_decoder
   import dxt_pkg::*;
(
   input  var logic            clock,
   input  var logic            reset,
   input  var logic            csr_wr_en,
   input  var logic            csr_wr_data,
   input  var logic            req_valid,
   output var logic            req_stall,
   input  var req_payload_type req_data,
   output var logic            rsp_valid,
   input  var logic            rsp_stall,
   output var rsp_payload_type rsp_data
);

   format_type      mode_ff;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;

   logic            pal_valid_ff, pal_valid_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   color_pal_type   cpal_ff;
   alpha_pal_type   apal_ff;
   logic [31:0]     cidx_ff, cidx_in;
   logic [47:0]     aidx_ff, aidx_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   color_pal_type   cpal_new;
   alpha_pal_type   apal_new;

   logic req_take, rsp_free, pix_go, pal_last, pal_load;

   dxt_color_pal u_color_pal (
      .mode      (mode_ff),
      .endpoint0 (in_data_ff.color_block[15:0]),
      .endpoint1 (in_data_ff.color_block[31:16]),
      .palette   (cpal_new)
   );

   dxt_alpha_pal u_alpha_pal (
      .a0      (in_data_ff.alpha_block[7:0]),
      .a1      (in_data_ff.alpha_block[15:8]),
      .palette (apal_new)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign pix_go    = pal_valid_ff && rsp_free;
   assign pal_last  = (cnt_ff == LastPixel);
   assign pal_load  = in_valid_ff && (!pal_valid_ff || (pix_go && pal_last));
   assign req_stall = in_valid_ff && !pal_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (pal_load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      pal_valid_in = pal_valid_ff;
      cnt_in       = cnt_ff;
      cidx_in      = cidx_ff;
      aidx_in      = aidx_ff;
      if (pal_load) begin
         pal_valid_in = 1'b1;
         cnt_in       = '0;
         cidx_in      = in_data_ff.color_block[63:32];
         aidx_in      = in_data_ff.alpha_block[63:16];
      end else if (pix_go) begin
         pal_valid_in = !pal_last;
         cnt_in       = cnt_ff + 1'b1;
         cidx_in      = {2'b00, cidx_ff[31:2]};
         aidx_in      = {3'b000, aidx_ff[47:3]};
      end
   end

   always_comb begin
      rgb_type c;
      c                      = cpal_ff[cidx_ff[1:0]];
      rsp_data_in.red        = c.r;
      rsp_data_in.green      = c.g;
      rsp_data_in.blue       = c.b;
      rsp_data_in.alpha      = (mode_ff == FMT_DXT5) ? apal_ff[aidx_ff[2:0]] : AlphaOpaque;
      rsp_data_in.pixel_x    = cnt_ff[1:0];
      rsp_data_in.pixel_y    = cnt_ff[3:2];
      rsp_data_in.last_pixel = pal_last;
      rsp_valid_in           = rsp_free ? pal_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= FMT_DXT1;
         in_valid_ff  <= 1'b0;
         pal_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= format_type'(csr_wr_data);
         end
         in_valid_ff  <= in_valid_in;
         pal_valid_ff <= pal_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (pal_load) begin
         cpal_ff <= cpal_new;
         apal_ff <= apal_new;
      end
      cidx_ff <= cidx_in;
      aidx_ff <= aidx_in;
      if (pix_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hw/rtl/dxt_checker.sv
// Port-level checks for dxt_block_decoder, bound to the top level.
// Depends on dxt_pkg and dxt_block_decoder.
`default_nettype none

module dxt_checker
   import dxt_pkg::*;
(
   input var logic            clock,
   input var logic            reset,
   input var logic            rsp_valid,
   input var logic            rsp_stall,
   input var rsp_payload_type rsp_data
);

   logic rsp_beat;
   assign rsp_beat = rsp_valid && !rsp_stall;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled rsp beat changed");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_pixel) |->
         (rsp_data.pixel_x == 2'd3 && rsp_data.pixel_y == 2'd3))
      else $error("last_pixel not on pixel (3,3)");

   a_pixel_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && !rsp_data.last_pixel) |=>
         (rsp_valid && ({rsp_data.pixel_y, rsp_data.pixel_x} ==
            4'($past({rsp_data.pixel_y, rsp_data.pixel_x}) + 4'd1))))
      else $error("gap or misorder inside a block");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_data.last_pixel) |=>
         (!rsp_valid || (rsp_data.pixel_x == 2'd0 && rsp_data.pixel_y == 2'd0)))
      else $error("block does not start at pixel (0,0)");

endmodule

bind dxt_block_decoder dxt_checker u_dxt_checker (.*);

`default_nettype wire

### test/testbench.sv
// Self-checking bench for dxt_block_decoder: DXT1 and DXT5 blocks go in, and each
// returned pixel beat is checked against a behavioral decoder kept inside this file.
// Depends on dxt_pkg and dxt_block_decoder only.
`timescale 1ns / 100ps

module testbench;
   import dxt_pkg::*;

   localparam int StallLimit = 2000;
   localparam int DrainCycles = 8;
   localparam int RandomPerPhase = 45;
   localparam logic [31:0] ColorRamp = 32'hE4E4_E4E4;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_wr_en = 1'b0;
   logic            csr_wr_data = 1'b0;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   req_payload_type block_q[$];
   rsp_payload_type pixel_q[$];
   format_type      fmt_shadow = FMT_DXT1;
   bit              steady = 1'b0;
   logic            req_taken = 1'b0;
   int              idle_cycles = 0;
   int              mismatches = 0;

   dxt_block_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // RGB565 channel to 8 bits by bit replication
   function automatic int unsigned expand_bits(int unsigned v, int bits);
      return ((v << (8 - bits)) | (v >> (2 * bits - 8))) & 8'hFF;
   endfunction

   // Pushes the sixteen pixels a block decodes to, in row-major order.
   function automatic void decode_block(req_payload_type blk);
      logic [15:0]     ep0, ep1;
      int unsigned     e0[3], e1[3], pal[4][3], apal[8];
      int unsigned     a0, a1, ci, ai;
      bit              four;
      rsp_payload_type px;
      ep0 = blk.color_block[15:0];
      ep1 = blk.color_block[31:16];
      four = (fmt_shadow == FMT_DXT5) || (ep0 > ep1);
      e0[0] = expand_bits(ep0[15:11], 5);
      e0[1] = expand_bits(ep0[10:5], 6);
      e0[2] = expand_bits(ep0[4:0], 5);
      e1[0] = expand_bits(ep1[15:11], 5);
      e1[1] = expand_bits(ep1[10:5], 6);
      e1[2] = expand_bits(ep1[4:0], 5);
      for (int ch = 0; ch < 3; ch++) begin
         pal[0][ch] = e0[ch];
         pal[1][ch] = e1[ch];
         if (four) begin
            pal[2][ch] = (2 * e0[ch] + e1[ch]) / 3;
            pal[3][ch] = (e0[ch] + 2 * e1[ch]) / 3;
         end else begin
            pal[2][ch] = (e0[ch] + e1[ch]) / 2;
            pal[3][ch] = 0;
         end
      end
      a0 = blk.alpha_block[7:0];
      a1 = blk.alpha_block[15:8];
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
         for (int j = 1; j < 7; j++) apal[1 + j] = ((7 - j) * a0 + j * a1) / 7;
      end else begin
         for (int j = 1; j < 5; j++) apal[1 + j] = ((5 - j) * a0 + j * a1) / 5;
         apal[6] = 0;
         apal[7] = 255;
      end
      for (int p = 0; p < 16; p++) begin
         ci = blk.color_block[32 + 2 * p +: 2];
         ai = blk.alpha_block[16 + 3 * p +: 3];
         px.red        = 8'(pal[ci][0]);
         px.green      = 8'(pal[ci][1]);
         px.blue       = 8'(pal[ci][2]);
         px.alpha      = (fmt_shadow == FMT_DXT5) ? 8'(apal[ai]) : 8'd255;
         px.pixel_x    = p[1:0];
         px.pixel_y    = p[3:2];
         px.last_pixel = (p == 15);
         pixel_q.push_back(px);
      end
   endfunction

   function automatic bit take_break();
      return !steady && ($urandom_range(99) < 38);
   endfunction

   // alpha indices 0..7 twice across the block
   function automatic logic [47:0] alpha_ramp();
      logic [47:0] r;
      for (int p = 0; p < 16; p++) r[3 * p +: 3] = p[2:0];
      return r;
   endfunction

   function automatic req_payload_type make_block(logic [15:0] c1, logic [15:0] c0,
                                                   logic [7:0] a1, logic [7:0] a0);
      req_payload_type blk;
      blk.color_block = {ColorRamp, c1, c0};
      blk.alpha_block = {alpha_ramp(), a1, a0};
      return blk;
   endfunction

   function automatic req_payload_type random_block();
      req_payload_type blk;
      int unsigned     pick;
      blk.color_block = {$urandom, $urandom};
      blk.alpha_block = {$urandom, $urandom};
      pick = $urandom_range(7);
      if (pick == 0) begin
         blk.color_block[31:16] = blk.color_block[15:0];
      end else if (pick == 1) begin
         blk.alpha_block[15:8] = blk.alpha_block[7:0];
      end
      return blk;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (block_q.size() != 0 || req_valid || pixel_q.size() != 0);
   endtask

   task automatic write_format(format_type f);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= f;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      fmt_shadow = f;
   endtask

   task automatic queue_random(int count);
      repeat (count) block_q.push_back(random_block());
   endtask

   // sender: one beat per handshake, held while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_break();
         if (!req_valid || req_taken) begin
            if (block_q.size() != 0 && !take_break()) begin
               req_data  <= block_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            decode_block(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixel_q.size() == 0) begin
               report_mismatch("pixel beat with none expected");
            end else begin
               want = pixel_q.pop_front();
               check_field("red", rsp_data.red, want.red);
               check_field("green", rsp_data.green, want.green);
               check_field("blue", rsp_data.blue, want.blue);
               check_field("alpha", rsp_data.alpha, want.alpha);
               check_field("pixel_x", rsp_data.pixel_x, want.pixel_x);
               check_field("pixel_y", rsp_data.pixel_y, want.pixel_y);
               check_field("last_pixel", rsp_data.last_pixel, want.last_pixel);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // DXT1: palette choice by endpoint order, alpha half ignored
      write_format(FMT_DXT1);
      block_q.push_back(make_block(16'h0000, 16'h0000, 8'h00, 8'h00));
      block_q.push_back('1);
      block_q.push_back(make_block(16'h0000, 16'hFFFF, 8'h12, 8'h34));
      block_q.push_back(make_block(16'hFFFF, 16'h0000, 8'hFF, 8'h00));
      block_q.push_back(make_block(16'h07E0, 16'hF800, 8'h00, 8'hFF));
      block_q.push_back(make_block(16'h001F, 16'h07E0, 8'h80, 8'h80));
      block_q.push_back(make_block(16'h1234, 16'h1235, 8'h55, 8'hAA));
      block_q.push_back(make_block(16'h1235, 16'h1234, 8'hAA, 8'h55));

      // DXT5: colour always four entries, alpha sevenths vs fifths
      write_format(FMT_DXT5);
      block_q.push_back(make_block(16'hFFFF, 16'h0000, 8'h00, 8'hFF));
      block_q.push_back(make_block(16'h0000, 16'hFFFF, 8'hFF, 8'h00));
      block_q.push_back(make_block(16'h1234, 16'h1234, 8'h80, 8'h80));
      block_q.push_back(make_block(16'hF800, 16'h001F, 8'h40, 8'h41));
      block_q.push_back(make_block(16'h001F, 16'hF800, 8'h41, 8'h40));
      block_q.push_back(make_block(16'h07E0, 16'h07E0, 8'hFF, 8'hFF));
      block_q.push_back('0);
      block_q.push_back('1);

      queue_random(RandomPerPhase);
      write_format(FMT_DXT1);
      queue_random(RandomPerPhase);

      // back-to-back stretch, no idling on either side
      write_format(FMT_DXT5);
      steady = 1'b1;
      queue_random(RandomPerPhase);
      wait_drained();
      steady = 1'b0;

      write_format(FMT_DXT1);
      queue_random(10);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
